### rtl/scfa_pkg.sv
package scfa_pkg;

    localparam int WORD_W            = 32;
    localparam int EXP_W             = 6;
    localparam int ORDER_W           = 4;
    localparam int OUTCOME_W         = 3;

    localparam int DEF_ADDR_BITS     = 32;
    localparam int DEF_NUM_CLASSES   = 16;
    localparam int DEF_STACK_DEPTH   = 64;
    localparam int DEF_LARGE_DEPTH   = 16;

    localparam logic [ORDER_W-1:0] ORDER_LIMIT_RESET = 4'd10;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_FROM_CLASS = 3'd0,
        OUT_FROM_LARGE = 3'd1,
        OUT_NONE_FREE  = 3'd2,
        OUT_STORED     = 3'd3,
        OUT_DROPPED    = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_READ
    } state_t;

    typedef struct packed {
        logic push;
        logic pull;
    } store_op_t;

    // smallest e with 2^e >= sz, zero for sizes zero and one
    function automatic logic [EXP_W-1:0] exponent_of(input logic [WORD_W-1:0] sz);
        logic [WORD_W-1:0] v;
        logic [EXP_W-1:0]  e;
        v = sz - WORD_W'(1);
        e = '0;
        if (sz > WORD_W'(1))
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                if (v[i])
                begin
                    e = EXP_W'(i + 1);
                end
            end
        end
        return e;
    endfunction

endpackage

### rtl/size_class_free_block_allocator.sv
// result: registered in the ACCESS state once the output is free, or in the
//   READ state, after the stack memory read, for a pop from a class stack;
//   no new input is taken until the result is loaded, so input is held off
//   while the output is stalled
// reset: asynchronous, active low; class counts and large list count cleared,
//   largest served class back to 10, stack memory contents left as they are
module size_class_free_block_allocator #(
    parameter int ADDR_BITS   = scfa_pkg::DEF_ADDR_BITS,
    parameter int NUM_CLASSES = scfa_pkg::DEF_NUM_CLASSES,
    parameter int STACK_DEPTH = scfa_pkg::DEF_STACK_DEPTH,
    parameter int LARGE_DEPTH = scfa_pkg::DEF_LARGE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [scfa_pkg::WORD_W-1:0]     size,
    input  logic [scfa_pkg::WORD_W-1:0]     address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [scfa_pkg::WORD_W-1:0]     block_address,
    output logic [scfa_pkg::OUTCOME_W-1:0]  outcome,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scfa_pkg::ORDER_W-1:0]    cfg_data
);

    import scfa_pkg::*;

    localparam int AW = (ADDR_BITS < WORD_W) ? ADDR_BITS : WORD_W;
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int NW = $clog2(STACK_DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  block_address_reg;
    outcome_t           outcome_reg;
    logic [ORDER_W-1:0] order_limit_reg;

    logic               action_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [AW-1:0]      addr_reg;

    logic               in_xfer;
    logic               out_free;
    logic [EXP_W-1:0]   top;
    logic               is_class;
    logic               class_pop_ok;

    store_op_t          class_op;
    store_op_t          list_op;
    logic [NW-1:0]      class_count;
    logic [AW-1:0]      pop_address;
    logic               list_full;
    logic               list_hit;
    logic [AW-1:0]      list_address;

    logic               load_out;
    logic [WORD_W-1:0]  res_address;
    outcome_t           res_outcome;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign top = (EXP_W'(order_limit_reg) > EXP_W'(NUM_CLASSES - 1))
               ? EXP_W'(NUM_CLASSES - 1) : EXP_W'(order_limit_reg);
    assign is_class     = (exp_reg <= top);
    assign class_pop_ok = !action_reg && is_class && (class_count != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    state_next = class_pop_ok ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        class_op    = '0;
        list_op     = '0;
        load_out    = 1'b0;
        res_address = '0;
        res_outcome = OUT_NONE_FREE;
        case (state_reg)
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    if (!action_reg)
                    begin
                        if (is_class)
                        begin
                            class_op.pull = class_pop_ok;
                            load_out      = !class_pop_ok;
                        end
                        else
                        begin
                            list_op.pull = 1'b1;
                            load_out     = 1'b1;
                            if (list_hit)
                            begin
                                res_address = WORD_W'(list_address);
                                res_outcome = OUT_FROM_LARGE;
                            end
                        end
                    end
                    else
                    begin
                        load_out = 1'b1;
                        if (is_class)
                        begin
                            class_op.push = (class_count != NW'(STACK_DEPTH));
                            res_outcome   = class_op.push ? OUT_STORED : OUT_DROPPED;
                        end
                        else
                        begin
                            list_op.push = !list_full;
                            res_outcome  = list_full ? OUT_DROPPED : OUT_STORED;
                        end
                    end
                end
            end
            ST_READ:
            begin
                load_out    = out_free;
                res_address = WORD_W'(pop_address);
                res_outcome = OUT_FROM_CLASS;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            order_limit_reg <= ORDER_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                order_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg <= action;
            exp_reg    <= exponent_of(size);
            addr_reg   <= AW'(address);
        end
        if (load_out)
        begin
            block_address_reg <= res_address;
            outcome_reg       <= res_outcome;
        end
    end

    assign out_valid     = out_valid_reg;
    assign block_address = block_address_reg;
    assign outcome       = outcome_reg;

    scfa_class_store #(
        .AW          (AW),
        .NUM_CLASSES (NUM_CLASSES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_class_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (class_op),
        .cls          (exp_reg[CW-1:0]),
        .push_address (addr_reg),
        .count        (class_count),
        .pop_address  (pop_address)
    );

    scfa_large_list #(
        .AW          (AW),
        .LARGE_DEPTH (LARGE_DEPTH)
    ) u_large_list (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (list_op),
        .exponent     (exp_reg),
        .push_address (addr_reg),
        .full         (list_full),
        .hit          (list_hit),
        .hit_address  (list_address)
    );

endmodule

### rtl/scfa_ram.sv
module scfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/scfa_class_store.sv
module scfa_class_store #(
    parameter int AW          = 32,
    parameter int NUM_CLASSES = 16,
    parameter int STACK_DEPTH = 64,
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    localparam int NW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scfa_pkg::store_op_t op,
    input  logic [CW-1:0]       cls,
    input  logic [AW-1:0]       push_address,
    output logic [NW-1:0]       count,
    output logic [AW-1:0]       pop_address
);

    import scfa_pkg::*;

    localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int RW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int SW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [NW-1:0] cnt_reg [NUM_CLASSES];
    logic [RW-1:0] base;
    logic [RW-1:0] wr_addr;
    logic [RW-1:0] rd_addr;

    assign count   = cnt_reg[cls];
    assign base    = RW'(cls) * RW'(STACK_DEPTH);
    assign wr_addr = base + RW'(SW'(count));
    assign rd_addr = base + RW'(SW'(count - NW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                if (cls == CW'(i))
                begin
                    if (op.push)
                    begin
                        cnt_reg[i] <= cnt_reg[i] + NW'(1);
                    end
                    else if (op.pull)
                    begin
                        cnt_reg[i] <= cnt_reg[i] - NW'(1);
                    end
                end
            end
        end
    end

    scfa_ram #(
        .WIDTH (AW),
        .DEPTH (RAM_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (op.push),
        .wr_addr (wr_addr),
        .wr_data (push_address),
        .rd_en   (op.pull),
        .rd_addr (rd_addr),
        .rd_data (pop_address)
    );

endmodule

### rtl/scfa_large_list.sv
module scfa_large_list #(
    parameter int AW          = 32,
    parameter int LARGE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scfa_pkg::store_op_t           op,
    input  logic [scfa_pkg::EXP_W-1:0]    exponent,
    input  logic [AW-1:0]                 push_address,
    output logic                          full,
    output logic                          hit,
    output logic [AW-1:0]                 hit_address
);

    import scfa_pkg::*;

    localparam int LNW = $clog2(LARGE_DEPTH + 1);
    localparam int LIW = (LARGE_DEPTH > 1) ? $clog2(LARGE_DEPTH) : 1;

    logic [AW-1:0]    addr_reg [LARGE_DEPTH];
    logic [EXP_W-1:0] exp_reg  [LARGE_DEPTH];
    logic [LNW-1:0]   count_reg;
    logic [LNW-1:0]   count_next;
    logic [LIW-1:0]   hit_idx;
    logic             take;

    // first entry, in insertion order, that is big enough
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = LARGE_DEPTH - 1; i >= 0; i--)
        begin
            if ((LNW'(i) < count_reg) && (exp_reg[i] >= exponent))
            begin
                hit     = 1'b1;
                hit_idx = LIW'(i);
            end
        end
    end

    assign hit_address = addr_reg[hit_idx];
    assign full        = (count_reg == LNW'(LARGE_DEPTH));
    assign take        = op.pull && hit;

    always_comb
    begin
        count_next = count_reg;
        if (op.push && !full)
        begin
            count_next = count_reg + LNW'(1);
        end
        else if (take)
        begin
            count_next = count_reg - LNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // removal shifts later entries down by one
    for (genvar j = 0; j < LARGE_DEPTH; j++)
    begin : g_entry
        if (j < LARGE_DEPTH - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (take && (LIW'(j) >= hit_idx))
                begin
                    addr_reg[j] <= addr_reg[j + 1];
                    exp_reg[j]  <= exp_reg[j + 1];
                end
                else if (op.push && !full && (count_reg == LNW'(j)))
                begin
                    addr_reg[j] <= push_address;
                    exp_reg[j]  <= exponent;
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (op.push && !full && (count_reg == LNW'(j)))
                begin
                    addr_reg[j] <= push_address;
                    exp_reg[j]  <= exponent;
                end
            end
        end
    end

endmodule
